FILE: hw/rtl/prc_pkg.sv
// Constants and the arctangent table for the polar/rectangular converter.
// No dependencies; imported by polar_rectangular_converter.
package prc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GUARD     = 16;
	localparam int CW        = 50;
	localparam int ZW        = 34;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint FIRST_MAX   = 64'sd1518500250;
	localparam longint SECOND_MAX  = 64'sd1073741823;
	localparam longint SECOND_MIN  = -64'sd1073741824;

	localparam logic [29:0] KGAIN = 30'd652032874;
	localparam logic [63:0] DEG_Q24_W = (64'd180 << 54) / 64'd3373259426;
	localparam logic [29:0] DEG_Q24 = DEG_Q24_W[29:0];

	localparam logic [29:0] ATAN_TAB [32] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
		30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
		30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
		30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
		30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
		30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
	};

endpackage

FILE: hw/rtl/polar_rectangular_converter.sv
// Pipelined CORDIC converter between polar and rectangular coordinates.
// Depends on prc_pkg for constants and the arctangent table.
//
// Takes one beat per clock cycle (busy stays low) and returns each result,
// marked by done for one cycle, after these registered steps in order: the
// gain multiply, quadrant setup, the CORDIC micro-rotation stages, the
// output multiply, and rounding and saturation.
// The receiver cannot stall, so results must be taken when done is high.
module polar_rectangular_converter #(
	parameter int ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [30:0] operand_a,
	input  logic signed [30:0] operand_b,
	output logic               done,
	output logic signed [31:0] first_result,
	output logic signed [30:0] second_result,
	output logic               status
);
	import prc_pkg::*;

	localparam int N = ITERATIONS;
	localparam logic signed [ZW-1:0] HALF = ZW'(HALF_PI_Q30);

	assign busy = 1'b0;

	// Stage 1: gain multiply and angle range check
	logic signed [60:0] prod_d;
	logic signed [44:0] zb_d;
	logic               bad_d;

	assign prod_d = operand_a * $signed({1'b0, KGAIN});
	assign zb_d   = 45'(operand_b) <<< (30 - FRAC_BITS);
	assign bad_d  = (zb_d > PI_Q30) || (zb_d < -PI_Q30);

	logic               v_s1;
	logic               mode_s1;
	logic               bad_s1;
	logic signed [60:0] prod_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [30:0] a_s1;
	logic signed [30:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		bad_s1  <= (mode == 1'b0) && bad_d;
		prod_s1 <= prod_d;
		z_s1    <= ZW'(zb_d);
		a_s1    <= operand_a;
		b_s1    <= operand_b;
	end

	// Stage 2: start vector and quadrant setup
	logic signed [61:0]   p_rnd;
	logic signed [CW-1:0] r0;
	logic signed [CW-1:0] xa;
	logic signed [CW-1:0] yb;
	logic signed [CW-1:0] x0_d;
	logic signed [CW-1:0] y0_d;
	logic signed [ZW-1:0] z0_d;

	assign p_rnd = 62'(prod_s1) + (62'sd1 <<< (30 - GUARD - 1));
	assign r0    = CW'(p_rnd >>> (30 - GUARD));
	assign xa    = CW'(a_s1) <<< GUARD;
	assign yb    = CW'(b_s1) <<< GUARD;

	always_comb begin
		if (!mode_s1) begin
			if (z_s1 > HALF) begin
				x0_d = '0;
				y0_d = r0;
				z0_d = z_s1 - HALF;
			end else if (z_s1 < -HALF) begin
				x0_d = '0;
				y0_d = -r0;
				z0_d = z_s1 + HALF;
			end else begin
				x0_d = r0;
				y0_d = '0;
				z0_d = z_s1;
			end
		end else begin
			if (xa < 0) begin
				if (yb >= 0) begin
					x0_d = yb;
					y0_d = -xa;
					z0_d = HALF;
				end else begin
					x0_d = -yb;
					y0_d = xa;
					z0_d = -HALF;
				end
			end else begin
				x0_d = xa;
				y0_d = yb;
				z0_d = '0;
			end
		end
	end

	logic signed [CW-1:0] cx_s [0:N];
	logic signed [CW-1:0] cy_s [0:N];
	logic signed [ZW-1:0] cz_s [0:N];
	logic                 cv_s [0:N];
	logic                 cm_s [0:N];
	logic                 cb_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= x0_d;
		cy_s[0] <= y0_d;
		cz_s[0] <= z0_d;
		cm_s[0] <= mode_s1;
		cb_s[0] <= bad_s1;
	end

	// Micro-rotation stages; rotation mode steers by z, vectoring mode by y
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic                 pos;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] at;

		assign dx  = cx_s[i] >>> i;
		assign dy  = cy_s[i] >>> i;
		assign at  = ZW'(ATAN_TAB[i]);
		assign pos = cm_s[i] ? cy_s[i][CW-1] : ~cz_s[i][ZW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (pos) begin
				cx_s[i+1] <= cx_s[i] - dy;
				cy_s[i+1] <= cy_s[i] + dx;
				cz_s[i+1] <= cz_s[i] - at;
			end else begin
				cx_s[i+1] <= cx_s[i] + dy;
				cy_s[i+1] <= cy_s[i] - dx;
				cz_s[i+1] <= cz_s[i] + at;
			end
			cm_s[i+1] <= cm_s[i];
			cb_s[i+1] <= cb_s[i];
		end
	end

	// Stage 3: drop guard bits (rotation) or scale magnitude and angle (vectoring)
	logic signed [50:0] rx_sum;
	logic signed [50:0] ry_sum;
	logic [34:0]        xs;
	logic [64:0]        pm1_d;
	logic signed [63:0] pm2_d;

	assign rx_sum = 51'(cx_s[N]) + (51'sd1 <<< (GUARD - 1));
	assign ry_sum = 51'(cy_s[N]) + (51'sd1 <<< (GUARD - 1));
	assign xs     = cx_s[N][48:14];
	assign pm1_d  = xs * KGAIN;
	assign pm2_d  = cz_s[N] * $signed({1'b0, DEG_Q24});

	logic               v_s3;
	logic               m_s3;
	logic               b_s3;
	logic signed [34:0] r1_s3;
	logic signed [34:0] r2_s3;
	logic [64:0]        pm1_s3;
	logic signed [63:0] pm2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= cv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		m_s3   <= cm_s[N];
		b_s3   <= cb_s[N];
		r1_s3  <= 35'(rx_sum >>> GUARD);
		r2_s3  <= 35'(ry_sum >>> GUARD);
		pm1_s3 <= pm1_d;
		pm2_s3 <= pm2_d;
	end

	// Stage 4: round, saturate, and zero out-of-range angles
	logic [65:0]        f1_sum;
	logic [33:0]        f1v;
	logic signed [64:0] s1_sum;
	logic signed [26:0] s1v;
	logic signed [31:0] first_d;
	logic signed [30:0] second_d;

	assign f1_sum = 66'(pm1_s3) + (66'd1 << 31);
	assign f1v    = f1_sum[65:32];
	assign s1_sum = 65'(pm2_s3) + (65'sd1 <<< (54 - FRAC_BITS - 1));
	assign s1v    = 27'(s1_sum >>> (54 - FRAC_BITS));

	always_comb begin
		if (b_s3) begin
			first_d  = '0;
			second_d = '0;
		end else if (!m_s3) begin
			if (r1_s3 > FIRST_MAX) begin
				first_d = 32'(FIRST_MAX);
			end else if (r1_s3 < -FIRST_MAX) begin
				first_d = 32'(-FIRST_MAX);
			end else begin
				first_d = 32'(r1_s3);
			end
			if (r2_s3 > SECOND_MAX) begin
				second_d = 31'(SECOND_MAX);
			end else if (r2_s3 < SECOND_MIN) begin
				second_d = 31'(SECOND_MIN);
			end else begin
				second_d = 31'(r2_s3);
			end
		end else begin
			if (f1v > FIRST_MAX) begin
				first_d = 32'(FIRST_MAX);
			end else begin
				first_d = 32'(f1v);
			end
			if (s1v > SECOND_MAX) begin
				second_d = 31'(SECOND_MAX);
			end else if (s1v < SECOND_MIN) begin
				second_d = 31'(SECOND_MIN);
			end else begin
				second_d = 31'(s1v);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_result  <= first_d;
		second_result <= second_d;
		status        <= b_s3;
	end

	a_valid_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		cv_s[N] |-> ##2 done)
		else $error("result beat lost after the rotation stages");

	a_bad_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (first_result == '0) && (second_result == '0))
		else $error("out-of-range angle produced nonzero outputs");

	a_bad_only_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> ($past(m_s3) == 1'b0))
		else $error("status raised on a rectangular-to-polar beat");

	a_first_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (first_result <= FIRST_MAX) && (first_result >= -FIRST_MAX))
		else $error("first_result outside its saturation range");

endmodule
